FILE: hw/rtl/psue_pkg.sv
// Package with shared types and constants for the particle swarm update engine.
`timescale 1ns / 1ps

package psue_pkg;

    localparam int NUM_PARTICLES_DEF = 64;
    localparam int NUM_DIMS_DEF      = 16;

    localparam int W_WIDTH    = 18;
    localparam int DATA_WIDTH = 32;
    localparam int RAND_WIDTH = 16;
    localparam int PIDX_WIDTH = 6;
    localparam int DIDX_WIDTH = 4;

    localparam logic [W_WIDTH-1:0] W_RESET = 18'd47776;
    localparam logic [16:0]        ACCEL_Q16 = 17'd97780;
    localparam logic signed [DATA_WIDTH-1:0] FIT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

endpackage

FILE: hw/rtl/particle_swarm_update_engine.sv
// Top level of the particle swarm update engine: memories, sequencer and stream ports.
`timescale 1ns / 1ps

// Usage
// The block keeps the swarm state in Q16.16 and takes one command per input beat on
// the s_axis channel; each command yields exactly one result beat on m_axis.
// Commands: load a position coordinate, update one coordinate (velocity and
// position with inertia weight), report a fitness, read a global best coordinate.
// The inertia weight is written through the cfg channel; the user must write it only
// while no item is in flight, as the block does not enforce it. Load, read, an
// out-of-range item and a report that improves nothing go from the read state straight
// to the emit state. An update passes through memory read, two coefficient and two
// difference products on one shared multiplier beside the inertia product, sum, round,
// saturate and write back. A report that improves a best copies each coordinate in a
// read and a write state through the registered read port of the position memory.
// One item is worked on at a time; the next can be taken in the cycle after the result
// reaches the output register. A stalled receiver keeps its beat in the output
// register; the next item is still taken and computed, and then waits until the held
// beat leaves.
// Reset: a clearing pass of NUM_PARTICLES*NUM_DIMS entries, one per cycle, zeroes
// the velocity and personal best memories and sets the personal best fitnesses to the
// lowest value; no item is accepted during it. Configuration writes are taken anytime.

module particle_swarm_update_engine #(
    parameter int NUM_PARTICLES = psue_pkg::NUM_PARTICLES_DEF,
    parameter int NUM_DIMS      = psue_pkg::NUM_DIMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] command, [7:2] particle_index, [11:8] dimension_index,
    // [43:12] data_value, [59:44] random_personal, [75:60] random_global
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] result_value, [32] own_best_improved, [33] global_best_improved,
    // [34] saturated
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [17:0] i_cfg_data
);

    localparam int DEPTH = NUM_PARTICLES * NUM_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int DW    = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
    localparam int DCW   = $clog2(NUM_DIMS + 1);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_READ   = 12'b000000000100,
        S_MUL_W  = 12'b000000001000,
        S_MUL_P  = 12'b000000010000,
        S_MUL_G  = 12'b000000100000,
        S_SUM    = 12'b000001000000,
        S_POS    = 12'b000010000000,
        S_COPY   = 12'b000100000000,
        S_COPYW  = 12'b001000000000,
        S_EMIT   = 12'b010000000000,
        S_COEF   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // Memories: one write and one read port each, registered read data.
    logic signed [31:0] m_pos  [DEPTH];
    logic signed [31:0] m_vel  [DEPTH];
    logic signed [31:0] m_pbst [DEPTH];
    logic signed [31:0] m_fit  [NUM_PARTICLES];

    logic [AW-1:0] r_addr;
    logic signed [31:0] r_pos_q, r_vel_q, r_pbst_q, r_fit_q;
    logic pos_we, vel_we, pbst_we, fit_we;
    logic [AW-1:0] pos_wa, vel_wa, pbst_wa;
    logic [PW-1:0] fit_wa, fit_ra;
    logic signed [31:0] pos_wd, vel_wd, pbst_wd, fit_wd;

    always_ff @(posedge i_clk) begin
        if (pos_we) m_pos[pos_wa] <= pos_wd;
        r_pos_q <= m_pos[r_addr];
    end
    always_ff @(posedge i_clk) begin
        if (vel_we) m_vel[vel_wa] <= vel_wd;
        r_vel_q <= m_vel[r_addr];
    end
    always_ff @(posedge i_clk) begin
        if (pbst_we) m_pbst[pbst_wa] <= pbst_wd;
        r_pbst_q <= m_pbst[r_addr];
    end
    always_ff @(posedge i_clk) begin
        if (fit_we) m_fit[fit_wa] <= fit_wd;
        r_fit_q <= m_fit[fit_ra];
    end

    logic [17:0] r_w;
    logic signed [31:0] r_fit_glb;
    logic signed [31:0] r_gbest [NUM_DIMS];

    // Item registers.
    psue_pkg::t_cmd r_cmd;
    logic [PW-1:0]  r_p;
    logic [DW-1:0]  r_d;
    logic signed [31:0] r_data;
    logic [15:0] r_r1, r_r2;
    logic r_ok;
    logic [AW-1:0] r_base;

    logic signed [66:0] r_acc;
    logic signed [50:0] r_prod;
    logic [16:0] r_c1, r_c2;
    logic signed [31:0] r_nv, r_gq;
    logic r_clip, r_own, r_glb;
    logic [DCW-1:0] r_cnt;
    logic [AW:0] r_clr;

    // Output register.
    logic        r_ovalid;
    logic [39:0] r_odata;
    logic [39:0] odata_nx;

    logic in_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_w <= psue_pkg::W_RESET;
        else if (i_cfg_valid) r_w <= i_cfg_data;
    end

    // Input decode.
    logic [5:0] in_p;
    logic [3:0] in_d;
    logic in_ok;
    assign in_p = s_axis_tdata[7:2];
    assign in_d = s_axis_tdata[11:8];
    always_comb begin
        in_ok = (32'(in_p) < 32'(NUM_PARTICLES));
        if (s_axis_tdata[1:0] != psue_pkg::CMD_REPORT)
            in_ok = in_ok && (32'(in_d) < 32'(NUM_DIMS));
    end

    // Fitness comparisons; the particle's best fitness is read at the accepting edge.
    logic own_gain, glb_gain;
    assign own_gain = (r_data > r_fit_q);
    assign glb_gain = (r_data > r_fit_glb);

    always_comb begin
        fit_we = 1'b0; fit_wa = r_p; fit_wd = r_data;
        fit_ra = (r_state == S_IDLE) ? PW'(in_p) : r_p;
        if (r_state == S_CLEAR) begin
            fit_we = (r_clr < (AW+1)'(NUM_PARTICLES));
            fit_wa = PW'(r_clr);
            fit_wd = psue_pkg::FIT_MIN;
        end else if (r_state == S_READ && r_cmd == psue_pkg::CMD_REPORT && r_ok
                     && own_gain) begin
            fit_we = 1'b1;
        end
    end

    // Multiplier operands: one shared signed 35x34 product per cycle.
    logic signed [34:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [32:0] dp, dg;
    assign dp = 33'(r_pbst_q) - 33'(r_pos_q);
    assign dg = 33'(r_gq) - 33'(r_pos_q);
    always_comb begin
        case (r_state)
            S_COEF: begin
                mul_a = 35'($signed({1'b0, psue_pkg::ACCEL_Q16}));
                mul_b = 34'($signed({1'b0, r_r1}));
            end
            S_MUL_W: begin
                mul_a = 35'($signed({1'b0, psue_pkg::ACCEL_Q16}));
                mul_b = 34'($signed({1'b0, r_r2}));
            end
            S_MUL_P: begin
                mul_a = 35'($signed({1'b0, r_c1}));
                mul_b = 34'(dp);
            end
            default: begin
                mul_a = 35'($signed({1'b0, r_c2}));
                mul_b = 34'(dg);
            end
        endcase
    end
    logic signed [68:0] mul_full;
    assign mul_full = mul_a * mul_b;

    // Rounding and saturation.
    logic signed [66:0] rnd;
    logic signed [50:0] shv;
    logic signed [32:0] sumx;
    logic vclip, xclip;
    logic signed [31:0] nv_sat, nx_sat;
    assign rnd = r_acc + 67'sd32768;
    assign shv = 51'(rnd >>> 16);
    always_comb begin
        vclip = 1'b0;
        if (shv > 51'(psue_pkg::VAL_MAX)) begin
            nv_sat = psue_pkg::VAL_MAX; vclip = 1'b1;
        end else if (shv < 51'(psue_pkg::FIT_MIN)) begin
            nv_sat = psue_pkg::FIT_MIN; vclip = 1'b1;
        end else begin
            nv_sat = shv[31:0];
        end
    end
    assign sumx = 33'(r_pos_q) + 33'(r_nv);
    always_comb begin
        xclip = 1'b0;
        if (sumx > 33'(psue_pkg::VAL_MAX)) begin
            nx_sat = psue_pkg::VAL_MAX; xclip = 1'b1;
        end else if (sumx < 33'(psue_pkg::FIT_MIN)) begin
            nx_sat = psue_pkg::FIT_MIN; xclip = 1'b1;
        end else begin
            nx_sat = sumx[31:0];
        end
    end

    logic [AW-1:0] item_addr;
    assign item_addr = AW'(32'(in_p) * NUM_DIMS + 32'(in_d));

    // Memory write control.
    always_comb begin
        pos_we = 1'b0; pos_wa = r_addr; pos_wd = r_data;
        vel_we = 1'b0; vel_wa = r_addr; vel_wd = r_nv;
        pbst_we = 1'b0; pbst_wa = r_addr; pbst_wd = r_pos_q;
        if (r_state == S_CLEAR) begin
            vel_we = 1'b1; vel_wa = r_clr[AW-1:0]; vel_wd = '0;
            pbst_we = 1'b1; pbst_wa = r_clr[AW-1:0]; pbst_wd = '0;
        end else if (r_state == S_READ && r_cmd == psue_pkg::CMD_LOAD && r_ok) begin
            pos_we = 1'b1;
        end else if (r_state == S_POS) begin
            pos_we = 1'b1; pos_wd = nx_sat;
            vel_we = 1'b1;
        end else if (r_state == S_COPYW && r_own) begin
            pbst_we = 1'b1;
        end
    end

    // Result beat assembled from the item registers.
    always_comb begin
        odata_nx = '0;
        if (r_ok) begin
            unique case (r_cmd)
                psue_pkg::CMD_UPDATE: begin
                    odata_nx[31:0] = r_data;
                    odata_nx[34] = r_clip;
                end
                psue_pkg::CMD_READ: odata_nx[31:0] = r_gq;
                psue_pkg::CMD_REPORT: begin
                    odata_nx[32] = r_own;
                    odata_nx[33] = r_glb;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == (AW+1)'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = S_READ;
            S_READ: begin
                if (!r_ok) n_state = S_EMIT;
                else begin
                    unique case (r_cmd)
                        psue_pkg::CMD_UPDATE: n_state = S_COEF;
                        psue_pkg::CMD_REPORT:
                            n_state = (own_gain || glb_gain) ? S_COPY : S_EMIT;
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_COEF:  n_state = S_MUL_W;
            S_MUL_W: n_state = S_MUL_P;
            S_MUL_P: n_state = S_MUL_G;
            S_MUL_G: n_state = S_SUM;
            S_SUM:   n_state = S_POS;
            S_POS:   n_state = S_EMIT;
            S_COPY:  n_state = S_COPYW;
            S_COPYW: n_state = (r_cnt == DCW'(NUM_DIMS - 1)) ? S_EMIT : S_COPY;
            S_EMIT:  if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_fit_glb <= psue_pkg::FIT_MIN;
            for (int j = 0; j < NUM_DIMS; j++) r_gbest[j] <= '0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (in_acc) begin
                    r_cmd  <= psue_pkg::t_cmd'(s_axis_tdata[1:0]);
                    r_p    <= PW'(in_p);
                    r_d    <= DW'(in_d);
                    r_data <= s_axis_tdata[43:12];
                    r_r1   <= s_axis_tdata[59:44];
                    r_r2   <= s_axis_tdata[75:60];
                    r_ok   <= in_ok;
                    r_addr <= item_addr;
                    r_base <= AW'(32'(in_p) * NUM_DIMS);
                    r_clip <= 1'b0;
                    r_own  <= 1'b0;
                    r_glb  <= 1'b0;
                end
                S_READ: begin
                    r_gq <= r_gbest[r_d];
                    r_cnt <= '0;
                    if (r_cmd == psue_pkg::CMD_REPORT && r_ok) begin
                        if (own_gain) r_own <= 1'b1;
                        if (glb_gain) begin
                            r_glb <= 1'b1; r_fit_glb <= r_data;
                        end
                        r_addr <= r_base;
                    end
                end
                S_COEF: r_prod <= 51'(mul_full);
                S_MUL_W: begin
                    r_c1 <= 17'((r_prod + 51'sd32768) >>> 16);
                    r_prod <= 51'(mul_full);
                    r_acc <= 67'($signed({1'b0, r_w})) * 67'(r_vel_q);
                end
                S_MUL_P: begin
                    r_c2 <= 17'((r_prod + 51'sd32768) >>> 16);
                    r_acc <= r_acc + 67'(mul_full);
                end
                S_MUL_G: r_acc <= r_acc + 67'(mul_full);
                S_SUM: begin
                    r_nv <= nv_sat;
                    r_clip <= vclip;
                end
                S_POS: begin
                    r_clip <= r_clip | xclip;
                    r_data <= nx_sat;
                end
                S_COPY: ;
                S_COPYW: begin
                    if (r_glb) r_gbest[DW'(r_cnt)] <= r_pos_q;
                    r_addr <= r_addr + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_EMIT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_odata <= odata_nx;
                end
                default: ;
            endcase
        end
    end

    ap_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during clearing pass");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");
    ap_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[34] && (m_axis_tdata[32] || m_axis_tdata[33])))
        else $error("saturation and improvement flags together");
    ap_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_READ))
        else $error("accept did not start an item");

endmodule
